// ===== src/fpid_pkg.sv =====
package fpid_pkg;

    // Operand widths of the serial units.
    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W = 48;
    localparam int CNT_W = 6;

    // Register indexes on the configuration channel.
    localparam logic [3:0] CFG_PROP_GAIN     = 4'd0;
    localparam logic [3:0] CFG_INTEG_GAIN    = 4'd1;
    localparam logic [3:0] CFG_DERIV_GAIN    = 4'd2;
    localparam logic [3:0] CFG_DRIVE_FLOOR   = 4'd3;
    localparam logic [3:0] CFG_DRIVE_CEILING = 4'd4;
    localparam logic [3:0] CFG_INTEG_FLOOR   = 4'd5;
    localparam logic [3:0] CFG_INTEG_CEILING = 4'd6;
    localparam logic [3:0] CFG_FILTER_WEIGHT = 4'd7;

    // Fixed new-sample weight of the output smoothing, 0.3 in Q0.16.
    localparam logic [16:0] SMOOTH_NEW = 17'd19661;
    localparam logic [16:0] Q_ONE = 17'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_PROP,
        ST_INTG,
        ST_INC,
        ST_DERIV,
        ST_DIV,
        ST_SMOOTH,
        ST_FINISH
    } fpid_state_t;

    // Round a Q32.32 product to Q16.16, nearest with ties toward plus infinity.
    function automatic logic signed [PROD_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + PROD_W'(32768);
        return t >>> 16;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32'sh7FFFFFFF);
        lo = PROD_W'(32'sh80000000);
        if (x > hi) begin
            return 32'sh7FFFFFFF;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // Clamp with the floor taking priority when the limits cross.
    function automatic logic signed [31:0] clamp32(input logic signed [31:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [31:0] y;
        y = (x < hi) ? x : hi;
        return (y > lo) ? y : lo;
    endfunction

endpackage

// ===== src/fpid_mul.sv =====
module fpid_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [fpid_pkg::MUL_W-1:0] mul_a,
    input  logic signed [fpid_pkg::MUL_W-1:0] mul_b,
    output logic                              done,
    output logic signed [fpid_pkg::PROD_W-1:0] prod
);
    import fpid_pkg::*;

    logic signed [MUL_W-1:0] mcand_reg;
    logic signed [MUL_W:0]   hi_reg;
    logic        [MUL_W-1:0] lo_reg;
    logic        [CNT_W-1:0] cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic signed [MUL_W:0]   addend;
    logic signed [MUL_W:0]   sum;

    // One multiplier bit per cycle; the sign bit subtracts the multiplicand.
    always_comb begin
        addend = '0;
        if (lo_reg[0]) begin
            if (cnt_reg == CNT_W'(MUL_W - 1)) begin
                addend = -(MUL_W+1)'(mcand_reg);
            end else begin
                addend = (MUL_W+1)'(mcand_reg);
            end
        end
        sum = hi_reg + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial product shifts right as multiplier bits are consumed.
    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= mul_a;
            hi_reg    <= '0;
            lo_reg    <= mul_b;
        end else if (busy_reg) begin
            hi_reg <= {sum[MUL_W], sum[MUL_W:1]};
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[MUL_W-1:0], lo_reg};

endmodule

// ===== src/fpid_div.sv =====
module fpid_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fpid_pkg::DIV_W-1:0]  dividend,
    input  logic [30:0]                 divisor,
    output logic                        done,
    output logic [fpid_pkg::DIV_W-1:0]  quot
);
    import fpid_pkg::*;

    logic [DIV_W-1:0] dq_reg;
    logic [DIV_W-1:0] dq_next;
    logic [30:0]      rem_reg;
    logic [30:0]      rem_next;
    logic [30:0]      dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      trial;
    logic             ge;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial    = {rem_reg, dq_reg[DIV_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? 31'(trial - {1'b0, dvs_reg}) : trial[30:0];
        dq_next  = {dq_reg[DIV_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

// ===== src/filtered_pid_controller_core.sv =====
// Channel   | Direction | Handshake             | Payload
// s_        | in        | s_tvalid / s_tready   | s_tuser: action; s_tdata: measurement,
//           |           |                       |   target, feedforward, time_step
// m_        | out       | m_tvalid / m_tready   | m_tdata: drive, integral
// cfg_      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word is worked on at a time. A run step uses the shared bit-serial multiplier
// up to six times and the bit-serial divider at most once; the divider is skipped
// when the time step is zero, and a restart goes straight to the finish state.
// The result waits in an output register, so the next word is taken while it stalls.
// Reset is synchronous and active low; no memory needs a clearing pass.
module filtered_pid_controller_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // measurement, target, feedforward, time_step, pad
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // drive, integral
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import fpid_pkg::*;

    fpid_state_t state_reg, state_next;

    logic signed [31:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [31:0] drive_floor_reg, drive_ceiling_reg;
    logic signed [31:0] integ_floor_reg, integ_ceiling_reg;
    logic        [16:0] filter_weight_reg;

    logic signed [31:0] meas_reg, target_reg, ff_reg;
    logic        [30:0] dt_reg;
    logic signed [31:0] filt_reg, prior_filt_reg, integ_reg, prior_drive_reg;
    logic               awaiting_reg;
    logic signed [31:0] p_reg, kie_reg, kd_reg, d_reg;

    logic               m_tvalid_reg;
    logic        [63:0] m_tdata_reg;
    logic               mul_launched_reg, div_launched_reg;

    logic               s_accept;
    logic               out_free;
    logic               mul_start, mul_done, div_start, div_done;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod, mr;
    logic [DIV_W-1:0]   div_quot, dividend;
    logic [16:0]        wclamp;
    logic signed [31:0] err_w, delta_w, raw_w, d_w;
    logic signed [32:0] filt_diff, smooth_diff;
    logic [31:0]        kd_mag;
    logic               d_neg;

    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            drive_floor_reg   <= '0;
            drive_ceiling_reg <= 32'sd65536;
            integ_floor_reg   <= -32'sd32768;
            integ_ceiling_reg <= 32'sd32768;
            filter_weight_reg <= 17'd3277;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                CFG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                CFG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                CFG_DRIVE_FLOOR:   drive_floor_reg   <= cfg_data;
                CFG_DRIVE_CEILING: drive_ceiling_reg <= cfg_data;
                CFG_INTEG_FLOOR:   integ_floor_reg   <= cfg_data;
                CFG_INTEG_CEILING: integ_ceiling_reg <= cfg_data;
                CFG_FILTER_WEIGHT: filter_weight_reg <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // Derived terms taken from the current state.
    always_comb begin
        wclamp      = (filter_weight_reg > Q_ONE) ? Q_ONE : filter_weight_reg;
        filt_diff   = 33'(meas_reg) - 33'(filt_reg);
        err_w       = sat32(PROD_W'(target_reg) - PROD_W'(filt_reg));
        delta_w     = sat32(PROD_W'(filt_reg) - PROD_W'(prior_filt_reg));
        raw_w       = sat32(PROD_W'(ff_reg) + PROD_W'(p_reg) + PROD_W'(integ_reg)
                            + PROD_W'(d_reg));
        smooth_diff = 33'(raw_w) - 33'(prior_drive_reg);
        mr          = rnd_q16(mul_prod);
        kd_mag      = kd_reg[31] ? 32'(-33'(kd_reg)) : 32'(kd_reg);
        d_neg       = kd_reg > 0;
        dividend    = {kd_mag, 16'd0} + DIV_W'(dt_reg[30:1]);
    end

    // Divider quotient to a signed, saturated derivative term.
    always_comb begin
        if (d_neg) begin
            d_w = (div_quot >= DIV_W'(33'h080000000)) ? 32'sh80000000
                                                       : -div_quot[31:0];
        end else begin
            d_w = (div_quot >= DIV_W'(33'h080000000)) ? 32'sh7FFFFFFF
                                                       : div_quot[31:0];
        end
    end

    // Multiplier operand select.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_FILT: begin
                mul_a = MUL_W'(wclamp);
                mul_b = MUL_W'(filt_diff);
            end
            ST_PROP: begin
                mul_a = MUL_W'(prop_gain_reg);
                mul_b = MUL_W'(err_w);
            end
            ST_INTG: begin
                mul_a = MUL_W'(integ_gain_reg);
                mul_b = MUL_W'(err_w);
            end
            ST_INC: begin
                mul_a = MUL_W'(kie_reg);
                mul_b = MUL_W'(dt_reg);
            end
            ST_DERIV: begin
                mul_a = MUL_W'(deriv_gain_reg);
                mul_b = MUL_W'(delta_w);
            end
            ST_SMOOTH: begin
                mul_a = MUL_W'(SMOOTH_NEW);
                mul_b = MUL_W'(smooth_diff);
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        state_next = ST_FINISH;
                    end else if (awaiting_reg) begin
                        state_next = ST_PROP;
                    end else begin
                        state_next = ST_FILT;
                    end
                end
            end
            ST_FILT:   if (mul_done) state_next = ST_PROP;
            ST_PROP:   if (mul_done) state_next = ST_INTG;
            ST_INTG:   if (mul_done) state_next = ST_INC;
            ST_INC: begin
                if (mul_done) state_next = (dt_reg == '0) ? ST_SMOOTH : ST_DERIV;
            end
            ST_DERIV:  if (mul_done) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_SMOOTH;
            ST_SMOOTH: if (mul_done) state_next = ST_FINISH;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_FILT, ST_PROP, ST_INTG, ST_INC, ST_DERIV, ST_SMOOTH: begin
                mul_start = !mul_launched_reg;
            end
            ST_DIV:    div_start = !div_launched_reg;
            ST_FINISH: ;
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            mul_launched_reg <= 1'b0;
            div_launched_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            awaiting_reg     <= 1'b1;
        end else begin
            state_reg <= state_next;
            if (mul_start) begin
                mul_launched_reg <= 1'b1;
            end else if (mul_done) begin
                mul_launched_reg <= 1'b0;
            end
            if (div_start) begin
                div_launched_reg <= 1'b1;
            end else if (div_done) begin
                div_launched_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept) begin
                awaiting_reg <= s_tuser;
            end
        end
    end

    // Datapath state and step values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg        <= '0;
            prior_filt_reg  <= '0;
            integ_reg       <= '0;
            prior_drive_reg <= '0;
        end else begin
            if (s_accept) begin
                meas_reg   <= s_tdata[31:0];
                target_reg <= s_tdata[63:32];
                ff_reg     <= s_tdata[95:64];
                dt_reg     <= s_tdata[126:96];
                if (s_tuser) begin
                    filt_reg        <= '0;
                    prior_filt_reg  <= '0;
                    integ_reg       <= '0;
                    prior_drive_reg <= '0;
                end else if (awaiting_reg) begin
                    // The first sample seeds the filter directly.
                    filt_reg       <= s_tdata[31:0];
                    prior_filt_reg <= s_tdata[31:0];
                end
            end
            if (mul_done) begin
                case (state_reg)
                    ST_FILT:  filt_reg <= sat32(PROD_W'(filt_reg) + mr);
                    ST_PROP:  p_reg    <= sat32(mr);
                    ST_INTG:  kie_reg  <= sat32(mr);
                    ST_INC: begin
                        integ_reg <= clamp32(sat32(PROD_W'(integ_reg) + PROD_W'(sat32(mr))),
                                             integ_floor_reg, integ_ceiling_reg);
                        d_reg     <= '0;
                    end
                    ST_DERIV: kd_reg <= sat32(mr);
                    ST_SMOOTH: begin
                        prior_filt_reg  <= filt_reg;
                        prior_drive_reg <= clamp32(sat32(PROD_W'(prior_drive_reg) + mr),
                                                   drive_floor_reg, drive_ceiling_reg);
                    end
                    default: ;
                endcase
            end
            if (div_done) begin
                d_reg <= d_w;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= {integ_reg, prior_drive_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    fpid_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    fpid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dt_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    // The serial units never run at the same time.
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_launched_reg && div_launched_reg))
        else $error("multiplier and divider both in use");

    // A multiplier result only arrives while a step is being worked.
    a_mul_done_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg != ST_IDLE && state_reg != ST_FINISH))
        else $error("multiplier result outside a step");

    // A finished step hands its result to the output register and frees the input.
    a_finish_hands_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished step did not reach the output");

endmodule

// ===== bench/filtered_pid_controller_core_tb.sv =====
module filtered_pid_controller_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpid_pkg::*;

    // Action codes carried in tuser.
    localparam bit ACT_RUN     = 1'b0;
    localparam bit ACT_RESTART = 1'b1;
    // An index beyond the register list; writes to it must be ignored.
    localparam logic [3:0] CFG_UNMAPPED = 4'd11;

    localparam longint ONE_Q16    = 65536;
    localparam longint NEW_WEIGHT = 19661;
    localparam longint OLD_WEIGHT = 45875;

    typedef struct {
        int drive;
        int integ;
    } pid_result_t;

    // Scoreboard: tracks the controller state, predicts each result and checks it.
    class pid_scoreboard;
        int kp, ki, kd;
        int drive_lo, drive_hi, integ_lo, integ_hi;
        int unsigned weight;
        int filt, prior_filt, integ_acc, prior_out;
        bit first_pending;
        pid_result_t pending_results[$];
        int errors;

        function new();
            kp = 0; ki = 0; kd = 0;
            drive_lo = 0; drive_hi = 65536;
            integ_lo = -32768; integ_hi = 32768;
            weight = 3277;
            filt = 0; prior_filt = 0; integ_acc = 0; prior_out = 0;
            first_pending = 1;
            errors = 0;
        endfunction

        static function int sat(longint x);
            if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (x < -64'sd2147483648) return 32'sh80000000;
            return int'(x);
        endfunction

        // Nearest rounding of a Q32.32 value to Q16.16, ties toward plus infinity.
        static function longint round_q16(longint x);
            return (x + 32768) >>> 16;
        endfunction

        static function int qmul(int a, longint b);
            return sat(round_q16(longint'(a) * b));
        endfunction

        static function int clamp(int x, int lo, int hi);
            int y;
            y = (x < hi) ? x : hi;
            return (y > lo) ? y : lo;
        endfunction

        function void write_reg(logic [3:0] idx, logic [31:0] data);
            case (idx)
                CFG_PROP_GAIN:     kp = int'(data);
                CFG_INTEG_GAIN:    ki = int'(data);
                CFG_DERIV_GAIN:    kd = int'(data);
                CFG_DRIVE_FLOOR:   drive_lo = int'(data);
                CFG_DRIVE_CEILING: drive_hi = int'(data);
                CFG_INTEG_FLOOR:   integ_lo = int'(data);
                CFG_INTEG_CEILING: integ_hi = int'(data);
                CFG_FILTER_WEIGHT: weight = data[16:0];
                default: ;
            endcase
        endfunction

        // Advance the controller by one accepted word and queue its result.
        function void note_word(bit action, int meas, int tgt, int ff, longint dt);
            longint w, num, mag, quot;
            int err, p, ki_err, inc, d, delta, kd_delta, raw, out;
            pid_result_t r;
            if (action == ACT_RESTART) begin
                filt = 0; prior_filt = 0; integ_acc = 0; prior_out = 0;
                first_pending = 1;
                r.drive = 0;
                r.integ = 0;
                pending_results.push_back(r);
                return;
            end
            if (first_pending) begin
                filt = meas;
                prior_filt = meas;
                first_pending = 0;
            end else begin
                w = (weight > ONE_Q16) ? ONE_Q16 : longint'(weight);
                filt = sat(round_q16(w * meas + (ONE_Q16 - w) * filt));
            end
            err = sat(longint'(tgt) - filt);
            p = qmul(kp, err);
            ki_err = qmul(ki, err);
            inc = qmul(ki_err, dt);
            integ_acc = clamp(sat(longint'(integ_acc) + inc), integ_lo, integ_hi);
            // Derivative on the filtered value, divided by the time step.
            d = 0;
            if (dt != 0) begin
                delta = sat(longint'(filt) - prior_filt);
                kd_delta = qmul(kd, delta);
                num = -longint'(kd_delta) * ONE_Q16;
                mag = (num < 0) ? -num : num;
                quot = (mag + dt / 2) / dt;
                if (quot > 64'sd2147483648) quot = 64'sd2147483648;
                d = sat((num < 0) ? -quot : quot);
            end
            raw = sat(longint'(ff) + p + integ_acc + d);
            out = clamp(sat(round_q16(NEW_WEIGHT * raw + OLD_WEIGHT * prior_out)),
                        drive_lo, drive_hi);
            prior_filt = filt;
            prior_out = out;
            r.drive = out;
            r.integ = integ_acc;
            pending_results.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [63:0] word);
            pid_result_t r;
            if (pending_results.size() == 0) begin
                report("unexpected result word, drive", int'(word[31:0]), 0);
                return;
            end
            r = pending_results.pop_front();
            if (int'(word[31:0]) != r.drive) report("drive", int'(word[31:0]), r.drive);
            if (int'(word[63:32]) != r.integ) report("integral", int'(word[63:32]), r.integ);
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_index;
    logic [31:0]  cfg_data;

    pid_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;

    filtered_pid_controller_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        #15_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Offer one word and wait until it is taken, with random gaps in front.
    task send_word(bit action, int meas, int tgt, int ff, logic [30:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= action;
        s_tdata <= {1'b0, dt, ff, tgt, meas};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(action, meas, tgt, ff, longint'(dt));
    endtask

    // Wait for every result, then let the block settle before touching registers.
    task drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Writes follow each other back to back; the caller drops cfg_valid afterward.
    task write_reg(logic [3:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task write_all(int p, int i, int d, int dlo, int dhi, int ilo, int ihi, int w);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_DRIVE_FLOOR, dlo);
        write_reg(CFG_DRIVE_CEILING, dhi);
        write_reg(CFG_INTEG_FLOOR, ilo);
        write_reg(CFG_INTEG_CEILING, ihi);
        write_reg(CFG_FILTER_WEIGHT, w);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Q16.16 value: mostly modest magnitudes, sometimes any pattern or an extreme.
    function automatic int rand_q();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return int'($urandom_range(1 << 20)) - (1 << 19);
        if (sel < 9) return int'($urandom);
        return ($urandom_range(1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
    endfunction

    function automatic logic [30:0] rand_dt();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) return 31'($urandom_range(131072, 1));
        if (sel < 9) return 31'($urandom_range(32'h7FFFFFFF, 1));
        return 31'h7FFFFFFF;
    endfunction

    initial begin
        int ph;
        int n;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_RUN;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PROP_GAIN;
        cfg_data = '0;
        send_idle_pct = 18;
        recv_idle_pct = 71;
        hold_cycles = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words with the reset settings: seeding, restart, field extremes.
        send_word(ACT_RUN, 32'sh00010000, 32'sh00020000, 0, 31'h10000);
        send_word(ACT_RUN, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF);
        send_word(ACT_RUN, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 31'h1);
        send_word(ACT_RESTART, 32'sh7FFFFFFF, 0, 0, 31'h7FFFFFFF);
        send_word(ACT_RUN, 32'sh80000000, 0, 32'sh00008000, 31'h100);
        drain();

        // Large gains, filter weight above one, crossed drive limits.
        write_all(32'sh00040000, 32'sh00020000, 32'sh00010000, 32'sh00008000,
                  32'shFFFF0000, 32'sh80000000, 32'sh7FFFFFFF, 17'h1FFFF);
        write_reg(CFG_UNMAPPED, 32'hFFFFFFFF);
        cfg_valid <= 1'b0;
        send_word(ACT_RUN, 32'sh00030000, 32'sh00010000, 0, 31'h8000);
        send_word(ACT_RUN, 32'sh00050000, 32'sh00010000, 0, 31'h0);
        send_word(ACT_RUN, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h1);
        send_word(ACT_RUN, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF);
        drain();

        // Extreme gains, zero filter weight, normal limits.
        write_all(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                  32'sh7FFFFFFF, 32'shFFFF0000, 32'sh00010000, 0);
        send_word(ACT_RESTART, 0, 0, 0, 31'h1);
        send_word(ACT_RUN, 32'sh00020000, 32'sh00010000, 0, 31'h10000);
        send_word(ACT_RUN, 32'sh7FFFFFFF, 32'sh00010000, 0, 31'h0);
        send_word(ACT_RUN, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h1);
        send_word(ACT_RUN, 32'sh00001000, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF);
        drain();

        // Random phases, each with new settings; the idling pattern changes every two phases.
        for (ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                send_idle_pct = 18;
                recv_idle_pct = 71;
            end else if (ph < 4) begin
                send_idle_pct = 71;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: write_all(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                             32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 17'h10000);
                2: write_all(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh00010000,
                             32'shFFFF0000, 32'sh00008000, 32'shFFFF8000, 17'h10001);
                default: write_all(int'($urandom_range(1 << 19)) - (1 << 18),
                                   int'($urandom_range(1 << 18)) - (1 << 17),
                                   int'($urandom_range(1 << 17)) - (1 << 16),
                                   -int'($urandom_range(1 << 20)),
                                   int'($urandom_range(1 << 20)),
                                   -int'($urandom_range(1 << 19)),
                                   int'($urandom_range(1 << 19)),
                                   $urandom_range(65536));
            endcase
            // The receiver holds off for a long stretch while words keep coming.
            if (ph == 3) hold_cycles = 1500;
            for (n = 0; n < 190; n++) begin
                send_word(($urandom_range(99) < 4) ? ACT_RESTART : ACT_RUN,
                          rand_q(), rand_q(), rand_q(), rand_dt());
            end
            drain();
        end

        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
